### src/lru_key_value_cache_top_assert.svh
// ----------------------------------------------------------------------------
// LRU key-value cache assertion macros
// Concurrent check wrappers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef LRU_KEY_VALUE_CACHE_TOP_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_TOP_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define LKV_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define LKV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define LKV_ASSERT_NOW(label, ante, cons, msg)
`define LKV_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

### src/lkv_pkg.sv
// ----------------------------------------------------------------------------
// LRU key-value cache package
// Shared widths, entry and control types, controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package lkv_pkg;

    localparam int KEY_W     = 32;
    localparam int VAL_W     = 32;
    localparam int CFG_W     = 5;
    localparam int CAP_RESET = 16;

    localparam logic signed [VAL_W-1:0] MISS_VALUE = '1;

    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    typedef struct packed {
        logic                    valid;
        logic signed [KEY_W-1:0] key;
        logic signed [VAL_W-1:0] value;
    } entry_t;

    typedef struct packed {
        logic                    cmp_en;
        logic                    shift;
        logic signed [KEY_W-1:0] cmp_key;
    } cell_ctl_t;

    typedef enum logic {
        ST_IDLE,
        ST_MOVE
    } state_t;

endpackage

`default_nettype wire

### src/lkv_if.sv
// ----------------------------------------------------------------------------
// LRU key-value cache channels
// Request and response valid/ready interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

interface lkv_req_if;
    import lkv_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    op;
    logic signed [KEY_W-1:0] key;
    logic signed [VAL_W-1:0] value;

    modport source (output valid, output op, output key, output value, input ready);
    modport sink   (input valid, input op, input key, input value, output ready);
endinterface

interface lkv_rsp_if;
    import lkv_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    hit;
    logic signed [VAL_W-1:0] read_value;

    modport source (output valid, output hit, output read_value, input ready);
    modport sink   (input valid, input hit, input read_value, output ready);
endinterface

`default_nettype wire

### src/lru_key_value_cache_top.sv
// ----------------------------------------------------------------------------
// LRU key-value cache
// Fully associative key-value store kept as a recency-ordered cell chain.
// ----------------------------------------------------------------------------
// Usage:
//   req carries op (0 get, 1 put), key and value; a request is taken when
//   valid and ready are both high. rsp returns hit and read_value, one
//   response per get and none per put; a miss answers hit 0, value -1.
//   cfg_we/cfg_wdata set the capacity in use; the write only lands while
//   the cache is empty (0 reads as 1, values above CAPACITY clamp).
// Steps:
//   A request passes an accept step, in which every cell compares the key
//   at once, and a move step, which moves entries one place down the chain
//   and loads the response register. No new request is taken until the
//   move step is done; a get's response reaches rsp from that register.
// Stall:
//   The response register decouples the sides: puts keep flowing while a
//   response waits; a get holds in its move cycle until the register frees.
// Reset: the cache comes up empty with capacity min(16, CAPACITY).
// ----------------------------------------------------------------------------
`default_nettype none

module lru_key_value_cache_top #(
    parameter int CAPACITY = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [lkv_pkg::CFG_W-1:0]       cfg_wdata,
    lkv_req_if.sink                         req,
    lkv_rsp_if.source                       rsp
);
    import lkv_pkg::*;

`include "lru_key_value_cache_top_assert.svh"

    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int CAP_W    = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam int CAP_INIT = (CAP_RESET < CAPACITY) ? CAP_RESET : CAPACITY;

    state_t                  state_reg, state_next;
    logic [CNT_W-1:0]        count_reg, count_next;
    logic [CAP_W-1:0]        cap_reg, cap_next;
    logic                    op_reg;
    logic signed [KEY_W-1:0] key_reg;
    logic signed [VAL_W-1:0] value_reg;
    logic                    out_valid_reg, out_valid_next;
    logic                    out_hit_reg, out_hit_next;
    logic signed [VAL_W-1:0] out_value_reg, out_value_next;

    logic                    accept;
    logic                    out_free;
    logic                    move_go;
    logic                    any_hit;
    logic                    full;
    logic [CAP_W-1:0]        cfg_val;
    logic signed [VAL_W-1:0] found_value;

    logic [CAPACITY-1:0]     valid_vec;
    logic [CAPACITY-1:0]     match_vec;
    logic [CAPACITY-1:0]     shift_vec;
    entry_t                  entry_arr [CAPACITY];
    logic signed [VAL_W-1:0] hitval_arr [CAPACITY];
    entry_t                  front;

    assign accept   = req.valid && req.ready;
    assign out_free = !out_valid_reg || rsp.ready;
    assign any_hit  = |match_vec;
    assign full     = CAP_W'(count_reg) >= cap_reg;

    always_comb
    begin
        found_value = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            found_value = found_value | hitval_arr[i];
        end
    end

    assign front = '{valid: 1'b1, key: key_reg,
                     value: (op_reg == OP_PUT) ? value_reg : found_value};

    // ---- cell chain ----
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        cell_ctl_t ctl;
        entry_t    prev;
        logic      shift_put;

        if (i == 0)
        begin : g_head
            assign prev      = front;
            assign shift_put = full ? valid_vec[i] : 1'b1;
        end
        else
        begin : g_body
            assign prev      = entry_arr[i-1];
            assign shift_put = full ? valid_vec[i] : valid_vec[i-1];
        end

        // on a hit, every position at or above the matched one moves down
        assign shift_vec[i] = any_hit ? |(match_vec >> i)
                                      : ((op_reg == OP_PUT) ? shift_put : 1'b0);

        assign ctl = '{cmp_en: accept, shift: move_go && shift_vec[i], cmp_key: req.key};

        lkv_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctl       (ctl),
            .prev      (prev),
            .entry     (entry_arr[i]),
            .match     (match_vec[i]),
            .hit_value (hitval_arr[i])
        );

        assign valid_vec[i] = entry_arr[i].valid;
    end

    // ---- controller ----
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_MOVE;
                end
            end
            ST_MOVE:
            begin
                if (move_go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req.ready = 1'b0;
        move_go   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req.ready = 1'b1;
            end
            ST_MOVE:
            begin
                move_go = (op_reg == OP_PUT) || out_free;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (move_go && (op_reg == OP_PUT) && !any_hit && !full)
        begin
            count_next = count_reg + CNT_W'(1);
        end
    end

    always_comb
    begin
        cfg_val = CAP_W'(cfg_wdata);
        if (cfg_val == '0)
        begin
            cfg_val = CAP_W'(1);
        end
        else if (cfg_val > CAP_W'(CAPACITY))
        begin
            cfg_val = CAP_W'(CAPACITY);
        end
        cap_next = (cfg_we && (count_reg == '0)) ? cfg_val : cap_reg;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !rsp.ready;
        out_hit_next   = out_hit_reg;
        out_value_next = out_value_reg;
        if (move_go && (op_reg == OP_GET))
        begin
            out_valid_next = 1'b1;
            out_hit_next   = any_hit;
            out_value_next = any_hit ? found_value : MISS_VALUE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            cap_reg       <= CAP_W'(CAP_INIT);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            cap_reg       <= cap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg    <= req.op;
            key_reg   <= req.key;
            value_reg <= req.value;
        end
        out_hit_reg   <= out_hit_next;
        out_value_reg <= out_value_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.hit        = out_hit_reg;
    assign rsp.read_value = out_value_reg;

    // ---- checks ----
    `LKV_ASSERT_NOW(a_match_onehot, state_reg == ST_MOVE, $onehot0(match_vec), "key in two cells")
    `LKV_ASSERT_NOW(a_count_valid, 1'b1, $countones(valid_vec) == int'(count_reg), "count drift")
    `LKV_ASSERT_NOW(a_count_cap, 1'b1, CAP_W'(count_reg) <= cap_reg, "count above capacity")
    `LKV_ASSERT_NEXT(a_get_resp, move_go && (op_reg == OP_GET), rsp.valid, "get lost response")

endmodule

`default_nettype wire

### src/lkv_cell.sv
// ----------------------------------------------------------------------------
// LRU key-value cache cell
// One recency position: holds an entry, compares it against a request key,
// and takes its upstream neighbor's entry when told to shift.
// ----------------------------------------------------------------------------
`default_nettype none

module lkv_cell (
    input  logic                                clk,
    input  logic                                rst_n,
    input  lkv_pkg::cell_ctl_t                  ctl,
    input  lkv_pkg::entry_t                     prev,
    output lkv_pkg::entry_t                     entry,
    output logic                                match,
    output logic signed [lkv_pkg::VAL_W-1:0]    hit_value
);
    import lkv_pkg::*;

    logic                    valid_reg, valid_next;
    logic                    match_reg, match_next;
    logic signed [KEY_W-1:0] key_reg, key_next;
    logic signed [VAL_W-1:0] value_reg, value_next;

    always_comb
    begin
        valid_next = ctl.shift ? prev.valid : valid_reg;
        key_next   = ctl.shift ? prev.key   : key_reg;
        value_next = ctl.shift ? prev.value : value_reg;
        match_next = ctl.cmp_en ? (valid_reg && (key_reg == ctl.cmp_key)) : match_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            match_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            match_reg <= match_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign entry     = '{valid: valid_reg, key: key_reg, value: value_reg};
    assign match     = match_reg;
    assign hit_value = match_reg ? value_reg : '0;

endmodule

`default_nettype wire
